/* sv/blist_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the bounded ordered list.
// No dependencies; imported by blist_cell and bounded_ordered_list.
package blist_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CAPACITY_MAX = 64;
  localparam int KW           = $clog2(CAPACITY_MAX);

  // request actions
  localparam logic [2:0] ACT_INSERT    = 3'd0;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd1;
  localparam logic [2:0] ACT_DEL_BACK  = 3'd2;
  localparam logic [2:0] ACT_DEL_MATCH = 3'd3;
  localparam logic [2:0] ACT_LIST      = 3'd4;

  // result status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // per-cycle cell operation
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_SHR  = 2'd1;  // take left neighbor
  localparam logic [1:0] CELL_SHL  = 2'd2;  // take right neighbor at and past k
  localparam logic [1:0] CELL_ROT  = 2'd3;  // take right neighbor, ring wraps

  typedef struct packed {
    logic [1:0]    op;
    logic [KW-1:0] k;
  } cell_ctrl_t;

endpackage

/* sv/bounded_ordered_list.sv */
`timescale 1ns / 1ps
// Bounded ordered list: a ring of CAPACITY cells plus the request sequencer.
// Depends on blist_pkg and blist_cell.
//
// Usage: a request (action, value) enters on in_valid/in_ready; results leave
// on out_valid/out_ready as (entry, status, last), last set on the final
// result of each request.
// Insert, delete front, delete back and any request on an empty list finish
// in the cycle they are accepted; the result shows up on the next cycle.
// Delete-by-value and list rotate the whole ring once through cell 0, one step
// a cycle while not paused, plus a closing step for delete-by-value.
// A list request sends one result per entry; the rotation pauses while the
// receiver holds off out_ready.
// A new request is taken while the sequencer is idle and the output register
// is free or being emptied in that cycle.
// Reset clears the length and the output valid; cell contents are not reset
// and are never read before being written.
module bounded_ordered_list import blist_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] entry,
  output logic [1:0]         status,
  output logic               last
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int LENW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]         state, state_next;
  logic [LENW-1:0]    length, length_next;
  logic [IDXW-1:0]    step, step_next;
  logic               list_mode, list_mode_next;
  logic               found, found_next;
  logic [KW-1:0]      k, k_next;
  logic signed [31:0] key, key_next;

  logic               emit;
  logic signed [31:0] emit_entry;
  logic [1:0]         emit_status;
  logic               emit_last;

  cell_ctrl_t         ctrl;
  logic signed [31:0] cell_q [CAPACITY];

  logic out_free, accept, in_list, go;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign in_list  = LENW'(step) < length;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (i == 0) begin : g_head
      assign left_d = value;
    end else begin : g_body
      assign left_d = cell_q[i-1];
    end
    assign right_d = cell_q[(i + 1) % CAPACITY];
    blist_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i])
    );
  end

  always_comb begin
    state_next     = state;
    length_next    = length;
    step_next      = step;
    list_mode_next = list_mode;
    found_next     = found;
    k_next         = k;
    key_next       = key;
    ctrl.op        = CELL_HOLD;
    ctrl.k         = '0;
    emit           = 1'b0;
    emit_entry     = '0;
    emit_status    = ST_OK;
    emit_last      = 1'b1;
    go             = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_INSERT: begin
              emit = 1'b1;
              if (length == LENW'(CAPACITY)) begin
                emit_status = ST_FULL;
              end else begin
                ctrl.op     = CELL_SHR;
                length_next = length + LENW'(1);
              end
            end
            ACT_DEL_FRONT: begin
              emit = 1'b1;
              if (length == '0) begin
                emit_status = ST_EMPTY;
              end else begin
                ctrl.op     = CELL_SHL;
                length_next = length - LENW'(1);
              end
            end
            ACT_DEL_BACK: begin
              emit = 1'b1;
              if (length == '0) begin
                emit_status = ST_EMPTY;
              end else begin
                length_next = length - LENW'(1);
              end
            end
            ACT_DEL_MATCH, ACT_LIST: begin
              if (length == '0) begin
                emit        = 1'b1;
                emit_status = ST_EMPTY;
              end else begin
                state_next     = S_SCAN;
                step_next      = '0;
                found_next     = 1'b0;
                list_mode_next = (action == ACT_LIST);
                key_next       = value;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      S_SCAN: begin
        // pause the rotation while a listed entry cannot be handed out
        go = (list_mode && in_list) ? out_free : 1'b1;
        if (go) begin
          ctrl.op = CELL_ROT;
          if (list_mode && in_list) begin
            emit       = 1'b1;
            emit_entry = cell_q[0];
            emit_last  = (LENW'(step) + LENW'(1)) == length;
          end
          if (!list_mode && in_list && !found && cell_q[0] == key) begin
            found_next = 1'b1;
            k_next     = KW'(step);
          end
          if (step == IDXW'(CAPACITY - 1)) begin
            state_next = list_mode ? S_IDLE : S_FINISH;
          end else begin
            step_next = step + IDXW'(1);
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (found) begin
            ctrl.op     = CELL_SHL;
            ctrl.k      = k;
            length_next = length - LENW'(1);
          end else begin
            emit_status = ST_NOTFOUND;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      length <= length_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step      <= step_next;
    list_mode <= list_mode_next;
    found     <= found_next;
    k         <= k_next;
    key       <= key_next;
    if (emit) begin
      entry  <= emit_entry;
      status <= emit_status;
      last   <= emit_last;
    end
  end

endmodule

/* sv/blist_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the list chain: holds a value, loads from a neighbor.
// Depends on blist_pkg for the cell operation codes and control struct.
module blist_cell import blist_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic signed [31:0] left_data,
  input  logic signed [31:0] right_data,
  output logic signed [31:0] data
);

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD: data <= data;
      CELL_SHR:  data <= left_data;
      CELL_ROT:  data <= right_data;
      CELL_SHL: begin
        // close the gap left by the removed entry
        if (KW'(IDX) >= ctrl.k) begin
          data <= right_data;
        end
      end
    endcase
  end

endmodule
